// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; ckf_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising edge outside reset.
`define CKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define CKF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CKF_ASSERT(lbl, prop, msg)
`define CKF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/ckf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckf_pkg: shared types and constants
// Command format, action codes, state encodings and day wrap helpers for the interpolator.
// ----------------------------------------------------------------------------
package ckf_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int NUM_CH       = 16;
  localparam int FIFO_DEPTH   = 2;
  localparam logic [15:0] DAY_UNITS = 16'd49152;
  localparam logic [3:0]  LAST_CH   = 4'd15;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_HOUR  = 2'd0,
    ACT_CHAN  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // Command kinds passed from front to back.
  typedef enum logic [1:0] {
    CMD_HOUR  = 2'd0,
    CMD_CHAN  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  key_index;
    logic [3:0]  channel_index;
    logic [15:0] value;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SEL,
    S_DIV,
    S_CH_RDA,
    S_CH_RDB,
    S_CH_MUL,
    S_CH_OUT
  } back_state_e;

  // Reduce an hour value modulo one day.
  function automatic logic [15:0] wrap_day(logic [15:0] v);
    return (v >= DAY_UNITS) ? (v - DAY_UNITS) : v;
  endfunction

  // Difference of two wrapped hours, modulo one day.
  function automatic logic [15:0] day_diff(logic [15:0] a, logic [15:0] b);
    return (a >= b) ? (a - b) : (a + DAY_UNITS - b);
  endfunction

endpackage

// ===== rtl/cyclic_keyframe_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_keyframe_interpolator: top level
// Cyclic piecewise linear interpolation of 16 channels over keyframe hours.
//
// Channel   Signals                 Payload (low bit first)
// in        s_axis_t*               tuser: action; tdata: key_index,
//                                   channel_index, key_value, query_hour
// out       m_axis_t*               tuser: channel; tdata: channel_value,
//                                   sample_hour; tlast: last
// config    cfg_we_i / cfg_wdata_i  key_count
//
// The executor writes key storage as it takes a write from the queue. A query is
// taken, then scanned with a read and an evaluate step per key; the keys are then
// selected, the bit serial divider forms the fraction, and each channel passes
// through reads of the lower and upper key from the channel memory, a multiply and an output.
// The front accepts an item each cycle while the two entry queue has room.
// Reset clears control state only; key storage is undefined until written.
// ----------------------------------------------------------------------------
module cyclic_keyframe_interpolator #(
  parameter int MaxKeys = ckf_pkg::MAX_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,    // key_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // action
  input  logic [39:0] s_axis_tdata,   // key_index, channel_index, key_value, query_hour
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [3:0]  m_axis_tuser,   // channel
  output logic [31:0] m_axis_tdata,   // channel_value, sample_hour
  output logic        m_axis_tlast
);

  logic [4:0]    key_count_q;
  logic          q_push, q_full, q_pop, q_empty;
  ckf_pkg::cmd_t q_in, q_out;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  ckf_front #(.MaxKeys(MaxKeys)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_in)
  );

  ckf_fifo #(.Depth(ckf_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_out),
    .empty_o (q_empty)
  );

  ckf_back #(.MaxKeys(MaxKeys)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_count_i   (key_count_q),
    .cmd_i         (q_out),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/ckf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckf_front: input classifier
// Accepts input items, drops those without effect, wraps query hours and
// turns the rest into commands for the queue.
// ----------------------------------------------------------------------------
module ckf_front #(
  parameter int MaxKeys = ckf_pkg::MAX_KEYS_DEF
) (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [1:0]    s_axis_tuser,
  input  logic [39:0]   s_axis_tdata,
  input  logic          q_full_i,
  output logic          q_push_o,
  output ckf_pkg::cmd_t q_cmd_o
);

  logic [3:0]  key_index;
  logic [3:0]  channel_index;
  logic [15:0] key_value;
  logic [15:0] query_hour;
  logic        keep;

  assign key_index     = s_axis_tdata[3:0];
  assign channel_index = s_axis_tdata[7:4];
  assign key_value     = s_axis_tdata[23:8];
  assign query_hour    = s_axis_tdata[39:24];

  assign s_axis_tready = !q_full_i;

  // Classify the item and build its command.
  always_comb begin
    keep                  = 1'b0;
    q_cmd_o.kind          = ckf_pkg::CMD_QUERY;
    q_cmd_o.key_index     = key_index;
    q_cmd_o.channel_index = channel_index;
    q_cmd_o.value         = key_value;
    unique case (s_axis_tuser)
      ckf_pkg::ACT_HOUR: begin
        keep         = (32'(key_index) < MaxKeys);
        q_cmd_o.kind = ckf_pkg::CMD_HOUR;
      end
      ckf_pkg::ACT_CHAN: begin
        keep         = (32'(key_index) < MaxKeys);
        q_cmd_o.kind = ckf_pkg::CMD_CHAN;
      end
      ckf_pkg::ACT_QUERY: begin
        keep          = 1'b1;
        q_cmd_o.value = ckf_pkg::wrap_day(query_hour);
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push_o = s_axis_tvalid && s_axis_tready && keep;

endmodule

// ===== rtl/ckf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckf_fifo: command queue
// Short register queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module ckf_fifo #(
  parameter int Depth = ckf_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ckf_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output ckf_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  ckf_pkg::cmd_t  mem_q [Depth];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign full_o  = (32'(cnt_q) == Depth);
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == Depth - 1) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (32'(rd_q) == Depth - 1) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/ckf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckf_back: command executor
// Writes key storage, scans keys for a query and divides once for the fraction
// (both skipped with no keys) and emits the sixteen interpolated channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ckf_back #(
  parameter int MaxKeys = ckf_pkg::MAX_KEYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [4:0]    key_count_i,
  input  ckf_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [3:0]    m_axis_tuser,
  output logic [31:0]   m_axis_tdata,
  output logic          m_axis_tlast
);

  localparam int IW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int CW = $clog2(MaxKeys + 1);
  localparam int AW = IW + 4;

  ckf_pkg::back_state_e state_q, state_d;

  logic [15:0]   hour_mem [MaxKeys];
  logic [15:0]   ch_mem   [MaxKeys * ckf_pkg::NUM_CH];
  logic [15:0]   hour_rd_q;
  logic [15:0]   ch_rd_q;
  logic [AW-1:0] ch_addr;

  logic [CW-1:0] n_sat;
  logic [CW-1:0] n_q;
  logic [CW-1:0] idx_q;
  logic [15:0]   h_q;
  logic          empty_q;
  logic [15:0]   w;

  logic          lo_vld_q, hi_vld_q;
  logic [IW-1:0] lo_idx_q, hi_idx_q, loa_idx_q, hia_idx_q;
  logic [15:0]   wlo_q, whi_q, wloa_q, whia_q;

  logic [IW-1:0] lo_q, hi_q;
  logic [15:0]   wsel_q;
  logic [15:0]   span_q, d_q, rem_q;
  logic [16:0]   rem2;
  logic [3:0]    div_cnt_q;
  logic [15:0]   t_q;
  logic [15:0]   sample_q;

  logic [3:0]          j_q;
  logic [15:0]         a_q;
  logic signed [16:0]  diff;
  logic signed [33:0]  prod_q;
  logic signed [17:0]  lerp;

  logic          out_vld_q;
  logic [3:0]    out_ch_q;
  logic [15:0]   out_val_q, out_hour_q;
  logic          out_last_q;
  logic          out_load;

  assign n_sat = (32'(key_count_i) > MaxKeys) ? CW'(MaxKeys) : CW'(key_count_i);
  assign pop_o = (state_q == ckf_pkg::S_IDLE) && !empty_i;
  assign w     = ckf_pkg::wrap_day(hour_rd_q);
  assign rem2  = {rem_q, 1'b0};
  assign diff  = $signed({1'b0, ch_rd_q}) - $signed({1'b0, a_q});
  assign lerp  = $signed({2'b00, a_q}) + $signed(prod_q[33:16]);
  assign out_load = (state_q == ckf_pkg::S_CH_OUT) && (!out_vld_q || m_axis_tready);

  // Channel read address: lower key first, then upper key.
  assign ch_addr = (state_q == ckf_pkg::S_CH_RDA) ? {lo_q, j_q} : {hi_q, j_q};

  // Key storage writes.
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == ckf_pkg::CMD_HOUR) begin
      hour_mem[IW'(cmd_i.key_index)] <= cmd_i.value;
    end
    if (pop_o && cmd_i.kind == ckf_pkg::CMD_CHAN) begin
      ch_mem[{IW'(cmd_i.key_index), cmd_i.channel_index}] <= cmd_i.value;
    end
  end

  // Registered reads.
  always_ff @(posedge clk_i) begin
    hour_rd_q <= hour_mem[idx_q[IW-1:0]];
    ch_rd_q   <= ch_mem[ch_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ckf_pkg::S_IDLE: begin
        if (pop_o && cmd_i.kind == ckf_pkg::CMD_QUERY) begin
          state_d = (n_sat == '0) ? ckf_pkg::S_CH_RDA : ckf_pkg::S_SCAN_RD;
        end
      end
      ckf_pkg::S_SCAN_RD: state_d = ckf_pkg::S_SCAN_EV;
      ckf_pkg::S_SCAN_EV: begin
        state_d = (idx_q == n_q - 1'b1) ? ckf_pkg::S_SEL : ckf_pkg::S_SCAN_RD;
      end
      ckf_pkg::S_SEL: state_d = ckf_pkg::S_DIV;
      ckf_pkg::S_DIV: begin
        if (span_q == '0 || d_q >= span_q || div_cnt_q == 4'd15) begin
          state_d = ckf_pkg::S_CH_RDA;
        end
      end
      ckf_pkg::S_CH_RDA: state_d = ckf_pkg::S_CH_RDB;
      ckf_pkg::S_CH_RDB: state_d = ckf_pkg::S_CH_MUL;
      ckf_pkg::S_CH_MUL: state_d = ckf_pkg::S_CH_OUT;
      ckf_pkg::S_CH_OUT: begin
        if (out_load) begin
          state_d = (j_q == ckf_pkg::LAST_CH) ? ckf_pkg::S_IDLE : ckf_pkg::S_CH_RDA;
        end
      end
      default: state_d = ckf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Query datapath: scan, select, divide and lerp.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ckf_pkg::S_IDLE: begin
        h_q      <= cmd_i.value;
        n_q      <= n_sat;
        idx_q    <= '0;
        j_q      <= '0;
        empty_q  <= (n_sat == '0);
        sample_q <= '0;
        lo_vld_q <= 1'b0;
        hi_vld_q <= 1'b0;
      end
      ckf_pkg::S_SCAN_EV: begin
        if (idx_q == '0 || w >= wloa_q) begin
          loa_idx_q <= idx_q[IW-1:0];
          wloa_q    <= w;
        end
        if (idx_q == '0 || w < whia_q) begin
          hia_idx_q <= idx_q[IW-1:0];
          whia_q    <= w;
        end
        if (w <= h_q) begin
          if (!lo_vld_q || w >= wlo_q) begin
            lo_vld_q <= 1'b1;
            lo_idx_q <= idx_q[IW-1:0];
            wlo_q    <= w;
          end
        end else if (!hi_vld_q || w < whi_q) begin
          hi_vld_q <= 1'b1;
          hi_idx_q <= idx_q[IW-1:0];
          whi_q    <= w;
        end
        idx_q <= idx_q + 1'b1;
      end
      ckf_pkg::S_SEL: begin
        lo_q      <= lo_vld_q ? lo_idx_q : loa_idx_q;
        hi_q      <= hi_vld_q ? hi_idx_q : hia_idx_q;
        wsel_q    <= lo_vld_q ? wlo_q : wloa_q;
        span_q    <= ckf_pkg::day_diff(hi_vld_q ? whi_q : whia_q, lo_vld_q ? wlo_q : wloa_q);
        d_q       <= ckf_pkg::day_diff(h_q, lo_vld_q ? wlo_q : wloa_q);
        rem_q     <= ckf_pkg::day_diff(h_q, lo_vld_q ? wlo_q : wloa_q);
        div_cnt_q <= '0;
        t_q       <= '0;
      end
      ckf_pkg::S_DIV: begin
        // One quotient bit per cycle; zero span and overflow finish at once.
        if (span_q == '0) begin
          t_q      <= '0;
          sample_q <= wsel_q;
        end else if (d_q >= span_q) begin
          t_q      <= 16'hFFFF;
          sample_q <= h_q;
        end else begin
          if (rem2 >= {1'b0, span_q}) begin
            rem_q <= 16'(rem2 - {1'b0, span_q});
            t_q   <= {t_q[14:0], 1'b1};
          end else begin
            rem_q <= rem2[15:0];
            t_q   <= {t_q[14:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + 1'b1;
          sample_q  <= h_q;
        end
      end
      ckf_pkg::S_CH_RDB: a_q <= ch_rd_q;
      ckf_pkg::S_CH_MUL: prod_q <= diff * $signed({1'b0, t_q});
      ckf_pkg::S_CH_OUT: begin
        if (out_load) begin
          j_q <= j_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= j_q;
      out_val_q  <= empty_q ? 16'd0 : lerp[15:0];
      out_hour_q <= sample_q;
      out_last_q <= (j_q == ckf_pkg::LAST_CH);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tdata  = {out_hour_q, out_val_q};
  assign m_axis_tlast  = out_last_q;

  `CKF_ASSERT(a_last_on_final, out_vld_q && out_last_q |-> out_ch_q == ckf_pkg::LAST_CH, "last on a channel other than the final one")
  `CKF_ASSERT(a_scan_in_range, state_q == ckf_pkg::S_SCAN_RD |-> idx_q < n_q, "key scan past the key count")
  `CKF_ASSERT(a_no_pop_busy, pop_o |-> state_q == ckf_pkg::S_IDLE, "command taken while busy")
  `CKF_ASSERT(a_div_ends, state_q == ckf_pkg::S_DIV && div_cnt_q == 4'd15 |=> state_q == ckf_pkg::S_CH_RDA, "divider overran")

endmodule
